[rtl/ecsw_pkg.sv]
package ecsw_pkg;

  localparam int MaxObs   = 64;
  localparam int NumTimes = 64;
  localparam int ObsW     = $clog2(MaxObs);
  localparam int TimeW    = $clog2(NumTimes);
  localparam int CntW     = ObsW + 1;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;
  localparam int WeightW  = 17;
  localparam int LimitW   = 31;
  localparam int RootW    = 24;

  localparam logic [CfgIdxW-1:0] CfgWeight = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLimit  = 2'd1;

  localparam logic [WeightW-1:0] OneQ        = 17'd65536;
  localparam logic [WeightW-1:0] WeightReset = 17'd13107;
  localparam logic [LimitW-1:0]  LimitReset  = 31'd196608;

  localparam logic OpLoad = 1'b0;
  localparam logic OpObs  = 1'b1;

  typedef enum logic [1:0] {
    SrcA = 2'd0,
    SrcB = 2'd1,
    SrcW = 2'd2
  } mac_src_e;

  typedef enum logic [1:0] {
    DivRow  = 2'd0,
    DivDiag = 2'd1,
    DivW    = 2'd2
  } div_sel_e;

  typedef struct packed {
    logic              op;
    logic              first_of_subject;
    logic [TimeW-1:0]  time_index;
    logic [TimeW-1:0]  column_index;
    logic signed [31:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] whitened_value;
    logic signed [31:0] ewma_value;
    logic               alarm;
    logic [ObsW-1:0]    obs_position;
  } out_item_t;

  typedef struct packed {
    logic            start;
    logic            cov_wr;
    logic            s_wr;
    logic            rad_rd;
    logic            mac_issue;
    mac_src_e        src;
    logic            acc_clr;
    logic            l_sat;
    logic            l_sq;
    logic            l_acc;
    logic            sq_start;
    logic            div_start;
    div_sel_e        div_sel;
    logic            u_wr;
    logic            w_wr;
    logic            ew_mul;
    logic            ew_sum;
    logic            out_load;
    logic [ObsW-1:0] i;
    logic [ObsW-1:0] k;
  } cmd_t;

  typedef struct packed {
    logic            stopped;
    logic            full;
    logic [ObsW-1:0] p;
    logic            mac_busy;
    logic            sq_busy;
    logic            div_busy;
    logic            out_free;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
    return (v + 64'sd32768) >>> 16;
  endfunction

endpackage

[rtl/ecsw_div.sv]
module ecsw_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic signed [63:0]             num_i,
  input  logic [ecsw_pkg::RootW-1:0]     den_i,
  output logic                           busy_o,
  output logic signed [31:0]             quot_o
);
  import ecsw_pkg::*;

  logic               busy_q;
  logic [5:0]         cnt_q;
  logic [48:0]        dvd_q;
  logic [RootW-1:0]   rem_q;
  logic [RootW-1:0]   den_q;
  logic               neg_q;
  logic signed [31:0] sat_n;
  logic [31:0]        mag;
  logic [48:0]        dvd_init;
  logic [RootW:0]     rem_sh;
  logic               ge;
  logic [RootW:0]     rem_nx;

  always_comb begin
    sat_n    = sat32(num_i);
    mag      = sat_n[31] ? (~sat_n + 32'd1) : sat_n;
    dvd_init = {1'b0, mag, 16'b0} + 49'(den_i >> 1);
    rem_sh   = {rem_q, dvd_q[48]};
    ge       = rem_sh >= {1'b0, den_q};
    rem_nx   = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
      if (cnt_q == 6'd48) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dvd_init;
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= sat_n[31];
    end else if (busy_q) begin
      rem_q <= rem_nx[RootW-1:0];
      dvd_q <= {dvd_q[47:0], ge};
    end
  end

  always_comb begin
    if (neg_q) begin
      if (dvd_q >= 49'h080000000) begin
        quot_o = 32'sh80000000;
      end else begin
        quot_o = -$signed(dvd_q[31:0]);
      end
    end else begin
      if (dvd_q > 49'h07FFFFFFF) begin
        quot_o = 32'sh7FFFFFFF;
      end else begin
        quot_o = $signed(dvd_q[31:0]);
      end
    end
  end

  assign busy_o = busy_q;

endmodule

[rtl/ecsw_sqrt.sv]
module ecsw_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [30:0]                rad_i,
  output logic                       busy_o,
  output logic [ecsw_pkg::RootW-1:0] root_o
);
  import ecsw_pkg::*;

  logic             busy_q;
  logic [4:0]       cnt_q;
  logic [47:0]      v_q;
  logic [25:0]      rem_q;
  logic [RootW-1:0] root_q;
  logic [27:0]      rem_sh;
  logic [27:0]      trial;
  logic             ge;
  logic [27:0]      rem_nx;

  always_comb begin
    rem_sh = {rem_q, v_q[47:46]};
    trial  = {2'b00, root_q, 2'b01};
    ge     = rem_sh >= trial;
    rem_nx = ge ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'(RootW - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q    <= {1'b0, rad_i, 16'b0};
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_nx[25:0];
      root_q <= {root_q[RootW-2:0], ge};
      v_q    <= {v_q[45:0], 2'b00};
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

[rtl/ecsw_datapath.sv]
module ecsw_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ecsw_pkg::in_item_t            in_data_i,
  input  logic                          cfg_wr_i,
  input  logic [ecsw_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ecsw_pkg::CfgDataW-1:0] cfg_data_i,
  input  ecsw_pkg::cmd_t                cmd_i,
  output ecsw_pkg::status_t             status_o,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output ecsw_pkg::out_item_t           out_data_o
);
  import ecsw_pkg::*;

  logic [WeightW-1:0] weight_q;
  logic [LimitW-1:0]  limit_q;

  logic signed [31:0] cov_mem   [NumTimes*NumTimes];
  logic signed [31:0] u_mem     [MaxObs*MaxObs];
  logic signed [31:0] svec_mem  [MaxObs];
  logic signed [31:0] lvec_mem  [MaxObs];
  logic signed [31:0] whist_mem [MaxObs];
  logic [TimeW-1:0]   thist_mem [MaxObs];

  logic signed [31:0] cov_rd_q, u_rd_q, svec_rd_q, lvec_rd_q, whist_rd_q;
  logic [TimeW-1:0]   thist_rd_q;
  logic [2*TimeW-1:0] cov_raddr;

  logic [TimeW-1:0]   t_q;
  logic signed [31:0] sample_q;
  logic [ObsW-1:0]    p_q;
  logic [ObsW-1:0]    p_new;
  logic signed [31:0] e_old_q;

  logic [CntW-1:0]    count_q;
  logic signed [31:0] ewma_q;
  logic               stopped_q;

  mac_src_e           src1_q;
  logic               v1_q, v2_q;
  logic signed [31:0] op_a, op_b;
  logic signed [63:0] prod_d, prod_q, acc_q;

  logic signed [31:0] l_q;
  logic signed [63:0] lsq_q, racc_q;
  logic signed [63:0] rad_full;
  logic [30:0]        rad;

  logic signed [31:0] acc_sat;
  logic signed [63:0] div_num;
  logic signed [31:0] div_res;
  logic               div_busy;
  logic [RootW-1:0]   root;
  logic               sq_busy;

  logic signed [31:0] w_q;
  logic [WeightW-1:0] lam, om;
  logic signed [63:0] m1_q, m2_q;
  logic signed [31:0] e_next, e_q;
  logic               alarm_d, alarm_q;

  logic               out_valid_q;
  out_item_t          out_data_q;
  logic               out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= WeightReset;
      limit_q  <= LimitReset;
    end else if (cfg_wr_i) begin
      case (cfg_index_i)
        CfgWeight: weight_q <= cfg_data_i[WeightW-1:0];
        CfgLimit:  limit_q  <= cfg_data_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  assign cov_raddr = cmd_i.rad_rd ? {t_q, t_q} : {thist_rd_q, t_q};
  assign p_new     = in_data_i.first_of_subject ? '0 : count_q[ObsW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.cov_wr) begin
      cov_mem[{in_data_i.time_index, in_data_i.column_index}] <= in_data_i.sample_value;
    end
    cov_rd_q <= cov_mem[cov_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.u_wr) begin
      u_mem[{p_q, cmd_i.k}] <= div_res;
    end
    u_rd_q <= u_mem[{cmd_i.i, cmd_i.k}];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.s_wr) begin
      svec_mem[cmd_i.k] <= cov_rd_q;
    end
    svec_rd_q <= svec_mem[cmd_i.k];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.l_sat) begin
      lvec_mem[cmd_i.i] <= acc_sat;
    end
    lvec_rd_q <= lvec_mem[cmd_i.i];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.w_wr) begin
      whist_mem[p_q] <= div_res;
    end
    whist_rd_q <= whist_mem[cmd_i.i];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      thist_mem[p_new] <= in_data_i.time_index;
    end
    thist_rd_q <= thist_mem[cmd_i.k];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      t_q      <= in_data_i.time_index;
      sample_q <= in_data_i.sample_value;
      p_q      <= p_new;
      e_old_q  <= in_data_i.first_of_subject ? 32'sd0 : ewma_q;
    end
  end

  always_comb begin
    case (src1_q)
      SrcA: begin
        op_a = u_rd_q;
        op_b = svec_rd_q;
      end
      SrcB: begin
        op_a = lvec_rd_q;
        op_b = u_rd_q;
      end
      SrcW: begin
        op_a = lvec_rd_q;
        op_b = whist_rd_q;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod_d = op_a * op_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.mac_issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    src1_q <= cmd_i.src;
    prod_q <= prod_d;
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + rnd16(prod_q);
    end
  end

  assign acc_sat = sat32(acc_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.l_sat) begin
      l_q <= acc_sat;
    end
    if (cmd_i.l_sq) begin
      lsq_q <= l_q * l_q;
    end
    if (cmd_i.start) begin
      racc_q <= '0;
    end else if (cmd_i.l_acc) begin
      racc_q <= racc_q + rnd16(lsq_q);
    end
  end

  always_comb begin
    rad_full = {{32{cov_rd_q[31]}}, cov_rd_q} - racc_q;
    rad      = (rad_full <= 64'sd0) ? 31'd1 : rad_full[30:0];
  end

  ecsw_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sq_start),
    .rad_i   (rad),
    .busy_o  (sq_busy),
    .root_o  (root)
  );

  always_comb begin
    case (cmd_i.div_sel)
      DivRow:  div_num = -{{32{acc_sat[31]}}, acc_sat};
      DivDiag: div_num = 64'sd65536;
      DivW:    div_num = {{32{sample_q[31]}}, sample_q} - acc_q;
      default: div_num = '0;
    endcase
  end

  ecsw_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (root),
    .busy_o  (div_busy),
    .quot_o  (div_res)
  );

  always_comb begin
    lam     = (weight_q > OneQ) ? OneQ : weight_q;
    om      = OneQ - lam;
    e_next  = sat32(rnd16(m1_q + m2_q));
    alarm_d = e_next >= $signed({1'b0, limit_q});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.w_wr) begin
      w_q <= div_res;
    end
    if (cmd_i.ew_mul) begin
      m1_q <= $signed({1'b0, om}) * e_old_q;
      m2_q <= $signed({1'b0, lam}) * w_q;
    end
    if (cmd_i.ew_sum) begin
      e_q     <= e_next;
      alarm_q <= alarm_d;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
      ewma_q      <= '0;
      stopped_q   <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
      count_q     <= {1'b0, p_q} + CntW'(1);
      ewma_q      <= e_q;
      stopped_q   <= alarm_q;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q.whitened_value <= w_q;
      out_data_q.ewma_value     <= e_q;
      out_data_q.alarm          <= alarm_q;
      out_data_q.obs_position   <= p_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    status_o.stopped  = stopped_q;
    status_o.full     = count_q >= CntW'(MaxObs);
    status_o.p        = p_q;
    status_o.mac_busy = v1_q || v2_q;
    status_o.sq_busy  = sq_busy;
    status_o.div_busy = div_busy;
    status_o.out_free = out_free;
  end

endmodule

[rtl/ecsw_ctrl.sv]
module ecsw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_op_i,
  input  logic              in_first_i,
  output logic              in_stall_o,
  input  ecsw_pkg::status_t status_i,
  output ecsw_pkg::cmd_t    cmd_o
);
  import ecsw_pkg::*;

  typedef enum logic [27:0] {
    StIdle = 28'd1 << 0,
    StSRt  = 28'd1 << 1,
    StSRc  = 28'd1 << 2,
    StSWr  = 28'd1 << 3,
    StAClr = 28'd1 << 4,
    StAMac = 28'd1 << 5,
    StADrn = 28'd1 << 6,
    StAL   = 28'd1 << 7,
    StASq  = 28'd1 << 8,
    StAAcc = 28'd1 << 9,
    StRRd  = 28'd1 << 10,
    StRSq  = 28'd1 << 11,
    StRWt  = 28'd1 << 12,
    StBClr = 28'd1 << 13,
    StBMac = 28'd1 << 14,
    StBDrn = 28'd1 << 15,
    StBDiv = 28'd1 << 16,
    StBWt  = 28'd1 << 17,
    StDDiv = 28'd1 << 18,
    StDWt  = 28'd1 << 19,
    StWClr = 28'd1 << 20,
    StWMac = 28'd1 << 21,
    StWDrn = 28'd1 << 22,
    StWDiv = 28'd1 << 23,
    StWWt  = 28'd1 << 24,
    StEMul = 28'd1 << 25,
    StESum = 28'd1 << 26,
    StOut  = 28'd1 << 27
  } state_e;

  state_e          state_q, state_d;
  logic [ObsW-1:0] i_q, i_d, k_q, k_d;
  logic [ObsW-1:0] p_last;

  assign p_last     = status_i.p - ObsW'(1);
  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    k_d     = k_q;
    cmd_o   = '0;
    cmd_o.src     = SrcA;
    cmd_o.div_sel = DivRow;
    cmd_o.i = i_q;
    cmd_o.k = k_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (in_op_i == OpLoad) begin
            cmd_o.cov_wr = 1'b1;
          end else if (in_first_i || !(status_i.stopped || status_i.full)) begin
            cmd_o.start = 1'b1;
            k_d     = '0;
            state_d = StSRt;
          end
        end
      end
      StSRt: begin
        if (k_q == status_i.p) begin
          i_d     = '0;
          state_d = StAClr;
        end else begin
          state_d = StSRc;
        end
      end
      StSRc: state_d = StSWr;
      StSWr: begin
        cmd_o.s_wr = 1'b1;
        k_d     = k_q + ObsW'(1);
        state_d = StSRt;
      end
      StAClr: begin
        if (i_q == status_i.p) begin
          state_d = StRRd;
        end else begin
          cmd_o.acc_clr = 1'b1;
          k_d     = '0;
          state_d = StAMac;
        end
      end
      StAMac: begin
        cmd_o.mac_issue = 1'b1;
        cmd_o.src       = SrcA;
        if (k_q == i_q) begin
          state_d = StADrn;
        end else begin
          k_d = k_q + ObsW'(1);
        end
      end
      StADrn: if (!status_i.mac_busy) state_d = StAL;
      StAL: begin
        cmd_o.l_sat = 1'b1;
        state_d = StASq;
      end
      StASq: begin
        cmd_o.l_sq = 1'b1;
        state_d = StAAcc;
      end
      StAAcc: begin
        cmd_o.l_acc = 1'b1;
        i_d     = i_q + ObsW'(1);
        state_d = StAClr;
      end
      StRRd: begin
        cmd_o.rad_rd = 1'b1;
        state_d = StRSq;
      end
      StRSq: begin
        cmd_o.sq_start = 1'b1;
        state_d = StRWt;
      end
      StRWt: begin
        if (!status_i.sq_busy) begin
          k_d     = '0;
          state_d = StBClr;
        end
      end
      StBClr: begin
        if (k_q == status_i.p) begin
          state_d = StDDiv;
        end else begin
          cmd_o.acc_clr = 1'b1;
          i_d     = k_q;
          state_d = StBMac;
        end
      end
      StBMac: begin
        cmd_o.mac_issue = 1'b1;
        cmd_o.src       = SrcB;
        if (i_q == p_last) begin
          state_d = StBDrn;
        end else begin
          i_d = i_q + ObsW'(1);
        end
      end
      StBDrn: if (!status_i.mac_busy) state_d = StBDiv;
      StBDiv: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DivRow;
        state_d = StBWt;
      end
      StBWt: begin
        if (!status_i.div_busy) begin
          cmd_o.u_wr = 1'b1;
          k_d     = k_q + ObsW'(1);
          state_d = StBClr;
        end
      end
      StDDiv: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DivDiag;
        state_d = StDWt;
      end
      StDWt: begin
        if (!status_i.div_busy) begin
          cmd_o.u_wr = 1'b1;
          i_d     = '0;
          state_d = StWClr;
        end
      end
      StWClr: begin
        cmd_o.acc_clr = 1'b1;
        state_d = (status_i.p == '0) ? StWDiv : StWMac;
      end
      StWMac: begin
        cmd_o.mac_issue = 1'b1;
        cmd_o.src       = SrcW;
        if (i_q == p_last) begin
          state_d = StWDrn;
        end else begin
          i_d = i_q + ObsW'(1);
        end
      end
      StWDrn: if (!status_i.mac_busy) state_d = StWDiv;
      StWDiv: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DivW;
        state_d = StWWt;
      end
      StWWt: begin
        if (!status_i.div_busy) begin
          cmd_o.w_wr = 1'b1;
          state_d = StEMul;
        end
      end
      StEMul: begin
        cmd_o.ew_mul = 1'b1;
        state_d = StESum;
      end
      StESum: begin
        cmd_o.ew_sum = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      i_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      k_q     <= k_d;
    end
  end

endmodule

[rtl/ewma_chart_sequential_whitening.sv]
// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_stall_o   in_data_i (in_item_t)
// out      output     out_valid_o/out_stall_i out_data_o (out_item_t)
// cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A covariance load is written while the block stays idle. An observation at
// position p is paced by the single multiply-accumulate pipeline over the
// factor triangle and by the divider, run once per new factor entry and once more for the whitened value.
// Reset is asynchronous, active low; the memories need no clearing pass.
// A finished result waits in the output register while the next item is taken;
// a stalled output holds the block only when the next result is ready.
module ewma_chart_sequential_whitening (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ecsw_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ecsw_pkg::out_item_t           out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ecsw_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ecsw_pkg::CfgDataW-1:0] cfg_data_i
);
  import ecsw_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  ecsw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_data_i.op),
    .in_first_i (in_data_i.first_of_subject),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ecsw_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_wr_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import ecsw_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  ewma_chart_sequential_whitening dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int errors = 0;

  // predictor state
  int cov_mem[NumTimes][NumTimes];
  int factor_mem[MaxObs][MaxObs];
  int white_hist[MaxObs];
  int time_hist[MaxObs];
  int ewma_acc = 0;
  int obs_cnt = 0;
  bit stopped = 1'b0;
  int unsigned weight_reg = WeightReset;
  int unsigned limit_reg = LimitReset;

  // stimulus bookkeeping
  bit cov_written[NumTimes][NumTimes];
  int subj_times[MaxObs];
  int subj_len = 0;

  function automatic longint sat_q(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint mul_round(longint a, longint b);
    return (a * b + 32768) >>> 16;
  endfunction

  function automatic longint div_round(longint num, longint den);
    longint n;
    longint unsigned mag, q;
    n = sat_q(num);
    mag = (n < 0) ? longint'(-n) : n;
    mag = mag << 16;
    q = (mag + longint'(den) / 2) / longint'(den);
    return sat_q(n < 0 ? -longint'(q) : longint'(q));
  endfunction

  function automatic longint sqrt_q(longint rad);
    longint unsigned v, res, b;
    res = 0;
    b = 64'd1 << 62;
    if (rad <= 0) rad = 1;
    v = longint'(rad) << 16;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return longint'(res);
  endfunction

  function automatic void whiten_observation(in_item_t it);
    longint lvec[MaxObs];
    longint acc, s, d, w, e, lam;
    int p, t;
    out_item_t r;
    t = it.time_index;
    if (it.op == OpLoad) begin
      cov_mem[t][it.column_index] = it.sample_value;
      return;
    end
    if (it.first_of_subject) begin
      obs_cnt = 0;
      ewma_acc = 0;
      stopped = 1'b0;
    end
    if (stopped || obs_cnt >= MaxObs) return;
    p = obs_cnt;
    time_hist[p] = t;
    acc = 0;
    for (int i = 0; i < p; i++) begin
      s = 0;
      for (int k = 0; k <= i; k++)
        s += mul_round(factor_mem[i][k], cov_mem[time_hist[k]][t]);
      lvec[i] = sat_q(s);
      acc += mul_round(lvec[i], lvec[i]);
    end
    d = sqrt_q(longint'(cov_mem[t][t]) - acc);
    for (int k = 0; k < p; k++) begin
      s = 0;
      for (int i = k; i < p; i++) s += mul_round(lvec[i], factor_mem[i][k]);
      factor_mem[p][k] = int'(div_round(-sat_q(s), d));
    end
    factor_mem[p][p] = int'(div_round(65536, d));
    acc = 0;
    for (int i = 0; i < p; i++) acc += mul_round(lvec[i], white_hist[i]);
    w = div_round(longint'(it.sample_value) - acc, d);
    white_hist[p] = int'(w);
    lam = (weight_reg > 65536) ? 65536 : weight_reg;
    if (p == 0) e = sat_q((lam * w + 32768) >>> 16);
    else e = sat_q(((65536 - lam) * longint'(ewma_acc) + lam * w + 32768) >>> 16);
    ewma_acc = int'(e);
    r.whitened_value = w[31:0];
    r.ewma_value = e[31:0];
    r.alarm = (e >= longint'(limit_reg));
    r.obs_position = p[ObsW-1:0];
    if (r.alarm) stopped = 1'b1;
    obs_cnt = p + 1;
    expected_results.push_back(r);
  endfunction

  task automatic report(string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // driver
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) whiten_observation(in_data);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int stall_mode = 0;
  int stall_cnt = 0;

  always @(posedge clk) begin
    out_item_t exp_item;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report("transfer with no result expected");
      end else begin
        exp_item = expected_results.pop_front();
        if (out_data.whitened_value !== exp_item.whitened_value)
          report($sformatf("whitened_value %0d exp %0d",
                           out_data.whitened_value, exp_item.whitened_value));
        if (out_data.ewma_value !== exp_item.ewma_value)
          report($sformatf("ewma_value %0d exp %0d",
                           out_data.ewma_value, exp_item.ewma_value));
        if (out_data.alarm !== exp_item.alarm)
          report($sformatf("alarm %0b exp %0b", out_data.alarm, exp_item.alarm));
        if (out_data.obs_position !== exp_item.obs_position)
          report($sformatf("obs_position %0d exp %0d",
                           out_data.obs_position, exp_item.obs_position));
      end
    end
    stall_cnt++;
    if (stall_cnt >= 97) begin
      stall_cnt = 0;
      stall_mode = $urandom_range(0, 2);
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 9) < 8);
    endcase
  end

  function automatic int pick_cov(bit diag);
    if (diag) begin
      case ($urandom_range(0, 9))
        0: return $urandom;
        1: return 0;
        default: return $urandom_range(32768, 262144);
      endcase
    end
    if ($urandom_range(0, 9) == 0) return $urandom;
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  function automatic int pick_sample();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      default: return int'($urandom_range(0, 262144)) - 131072;
    endcase
  endfunction

  function automatic void add_load(int r, int c, int v, bit mark);
    in_item_t it;
    it.op = OpLoad;
    it.first_of_subject = mark;
    it.time_index = TimeW'(r);
    it.column_index = TimeW'(c);
    it.sample_value = v;
    cov_written[r][c] = 1'b1;
    pending_items.push_back(it);
  endfunction

  function automatic void need_cov(int r, int c);
    if (!cov_written[r][c]) add_load(r, c, pick_cov(r == c), 1'($urandom_range(0, 1)));
  endfunction

  function automatic void add_obs(int t, bit first, int v);
    in_item_t it;
    if (first) subj_len = 0;
    for (int k = 0; k < subj_len; k++) need_cov(subj_times[k], t);
    need_cov(t, t);
    it.op = OpObs;
    it.first_of_subject = first;
    it.time_index = TimeW'(t);
    it.column_index = TimeW'($urandom_range(0, 63));
    it.sample_value = v;
    pending_items.push_back(it);
    if (subj_len < MaxObs) begin
      subj_times[subj_len] = t;
      subj_len++;
    end
  endfunction

  function automatic void random_phase(int n_obs);
    int done_obs, len;
    done_obs = 0;
    while (done_obs < n_obs) begin
      if ($urandom_range(0, 9) == 0) begin
        add_load($urandom_range(0, 63), $urandom_range(0, 63), $urandom, 1'b0);
      end else begin
        len = $urandom_range(1, 8);
        for (int j = 0; j < len; j++) begin
          add_obs($urandom_range(0, 63),
                  (j == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 15) == 0),
                  pick_sample());
          done_obs++;
        end
      end
    end
  endfunction

  task automatic drain();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (9000) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CfgWeight) weight_reg = val[WeightW-1:0];
    else if (idx == CfgLimit) limit_reg = val[LimitW-1:0];
    @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_load(0, 0, 32'h0001_0000, 1'b1);
    add_obs(0, 1'b0, 32'h7FFF_FFFF);
    add_obs(0, 1'b0, 32'h8000_0000);
    add_load(63, 63, -5, 1'b0);
    add_obs(63, 1'b1, 32'h0001_0000);
    add_load(63, 0, 32'h7FFF_FFFF, 1'b0);
    add_load(0, 63, 32'h8000_0000, 1'b0);
    add_obs(0, 1'b0, -1);
    add_obs(42, 1'b1, 0);
    add_obs(21, 1'b0, 32'h7FFF_FFFF);
    add_obs(21, 1'b0, 32'h7FFF_FFFF);
    add_obs(42, 1'b0, 32'h8000_0000);
    random_phase(3);
    drain();

    write_reg(CfgWeight, 32'hFFFF_FFFF);
    write_reg(CfgLimit, 32'h0);
    write_reg(2'd2, $urandom);
    write_reg(2'd3, 32'hFFFF_FFFF);
    random_phase(2);
    drain();

    // fill one subject to capacity, then one more observation
    write_reg(CfgWeight, 32'h1);
    write_reg(CfgLimit, 32'h7FFF_FFFF);
    for (int p = 0; p <= MaxObs; p++)
      add_obs(p % 4, p == 0, int'($urandom_range(0, 512)) - 256);
    drain();

    write_reg(CfgWeight, $urandom_range(1, 65536));
    write_reg(CfgLimit, $urandom_range(0, 32'h60000));
    random_phase(3);
    drain();

    if (errors == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

  initial begin
    #40ms;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
